// ===== hdl/tsi_pkg.sv =====
// Shared types and constants for the true strength index unit.
// No dependencies; imported by every module of the block.
package tsi_pkg;

   // Defaults for the top-level parameters
   localparam int PRICE_WIDTH_DEFAULT = 32;
   localparam int ALPHA_FRAC_DEFAULT  = 16;

   // Smoothing factor reset values, given in Q0.16
   localparam int ALPHA_RESET_FRAC    = 16;
   localparam int FIRST_ALPHA_RESET   = 5041;
   localparam int SECOND_ALPHA_RESET  = 9362;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_ALPHA  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_ALPHA = 2'd1;

   // Index output format: signed Q7.16, full scale +-100
   localparam int INDEX_WIDTH  = 24;
   localparam int INDEX_FRAC   = 16;
   localparam int HUNDRED_BITS = 7;
   localparam int QUOT_BITS    = HUNDRED_BITS + INDEX_FRAC;
   localparam logic [INDEX_WIDTH-1:0] INDEX_FULL = 24'd6553600;
   localparam logic [HUNDRED_BITS-1:0] SCALE_HUNDRED = 7'd100;

   // What the front end hands to the back end for each transaction
   typedef enum logic {
      ITEM_SKIP = 1'b0,   // result is invalid, state untouched
      ITEM_MOVE = 1'b1    // carries a momentum sample
   } item_kind_type;

endpackage

// ===== hdl/tsi_queue.sv =====
// Two-entry FIFO decoupling the front end from the back end.
// Depends on tsi_pkg (for the default data width).
module tsi_queue
   import tsi_pkg::*;
#(
   parameter int DATA_WIDTH = PRICE_WIDTH_DEFAULT + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W:0]        count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/tsi_front.sv =====
// Front end: accepts price transactions, tracks the previous price and
// classifies each sample into a skip or a momentum entry. Uses tsi_pkg.
module tsi_front
   import tsi_pkg::*;
#(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PRICE_WIDTH-1:0] req_price,
   input  logic                   req_price_missing,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [PRICE_WIDTH+1:0] push_data
);

   localparam int MW = PRICE_WIDTH + 1;

   logic signed [PRICE_WIDTH-1:0] last_price_ff;
   logic                          have_last_ff;
   logic signed [MW-1:0]          momentum;
   item_kind_type                 kind;
   logic                          accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && req_ready;

   assign momentum = MW'(signed'(req_price)) - MW'(last_price_ff);
   assign kind     = (req_price_missing || !have_last_ff) ? ITEM_SKIP : ITEM_MOVE;
   assign push_data = {kind, momentum};

   always_ff @(posedge clock) begin
      if (accept && !req_price_missing) begin
         last_price_ff <= req_price;
      end
      if (reset) begin
         have_last_ff <= 1'b0;
      end else if (accept && !req_price_missing) begin
         have_last_ff <= 1'b1;
      end
   end

endmodule

// ===== hdl/tsi_back.sv =====
// Back end: double exponential smoothing of momentum and its magnitude,
// a restoring divider for the ratio, and the result register. Uses tsi_pkg.
module tsi_back
   import tsi_pkg::*;
#(
   parameter int PRICE_WIDTH     = PRICE_WIDTH_DEFAULT,
   parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ALPHA_FRAC_BITS:0]     first_alpha,
   input  logic [ALPHA_FRAC_BITS:0]     second_alpha,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [PRICE_WIDTH+1:0]       pop_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [INDEX_WIDTH-1:0] rsp_index_value,
   output logic                         rsp_index_valid
);

   localparam int F     = ALPHA_FRAC_BITS;
   localparam int MW    = PRICE_WIDTH + 1;       // momentum
   localparam int AW    = PRICE_WIDTH + 2;       // averages and differences
   localparam int PW    = AW + F + 2;            // scaled difference product
   localparam int DW    = PRICE_WIDTH + 1;       // divider operands
   localparam int CNT_W = $clog2(QUOT_BITS);
   localparam logic [F:0]    ALPHA_ONE = (F+1)'(1) << F;
   localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (F - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_ADD1,
      ST_MUL2,
      ST_ADD2,
      ST_CHECK,
      ST_DIV,
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type             state_ff;
   logic                  seeded_ff;
   logic signed [AW-1:0]  x_ff;
   logic signed [AW-1:0]  ax_ff;
   logic signed [AW-1:0]  mv1_ff;
   logic signed [AW-1:0]  mv2_ff;
   logic signed [AW-1:0]  sz1_ff;
   logic signed [AW-1:0]  sz2_ff;
   logic signed [PW-1:0]  pm_ff;
   logic signed [PW-1:0]  ps_ff;
   logic [DW-1:0]         rem_ff;
   logic [DW-1:0]         den_ff;
   logic [QUOT_BITS-1:0]  low_ff;
   logic [QUOT_BITS-1:0]  quot_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  neg_ff;
   logic signed [INDEX_WIDTH-1:0] res_value_ff;
   logic                  res_valid_ff;
   logic                  rsp_valid_ff;
   logic signed [INDEX_WIDTH-1:0] rsp_value_ff;
   logic                  rsp_flag_ff;

   item_kind_type         kind;
   logic signed [MW-1:0]  pop_m;
   logic signed [AW-1:0]  pop_x;
   logic signed [AW-1:0]  pop_ax;
   logic [F:0]            a1_eff;
   logic [F:0]            a2_eff;
   logic signed [F+1:0]   a1_s;
   logic signed [F+1:0]   a2_s;
   logic signed [AW-1:0]  d_mv1;
   logic signed [AW-1:0]  d_sz1;
   logic signed [AW-1:0]  d_mv2;
   logic signed [AW-1:0]  d_sz2;
   logic signed [PW-1:0]  pm_rnd;
   logic signed [PW-1:0]  ps_rnd;
   logic signed [AW-1:0]  step_m;
   logic signed [AW-1:0]  step_s;
   logic signed [AW-1:0]  mag;
   logic [DW-1:0]         num;
   logic [DW-1:0]         den;
   logic [DW+HUNDRED_BITS-1:0] num100;
   logic [DW:0]           trial;
   logic                  trial_ge;
   logic                  round_up;
   logic [INDEX_WIDTH-1:0] q_round;
   logic [INDEX_WIDTH-1:0] q_clamp;
   logic                  out_free;

   assign kind   = item_kind_type'(pop_data[MW]);
   assign pop_m  = signed'(pop_data[MW-1:0]);
   assign pop_x  = AW'(pop_m);
   assign pop_ax = (pop_m < 0) ? -pop_x : pop_x;

   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign a1_eff = (first_alpha > ALPHA_ONE) ? ALPHA_ONE : first_alpha;
   assign a2_eff = (second_alpha > ALPHA_ONE) ? ALPHA_ONE : second_alpha;
   assign a1_s   = signed'({1'b0, a1_eff});
   assign a2_s   = signed'({1'b0, a2_eff});

   assign d_mv1 = x_ff - mv1_ff;
   assign d_sz1 = ax_ff - sz1_ff;
   assign d_mv2 = mv1_ff - mv2_ff;
   assign d_sz2 = sz1_ff - sz2_ff;

   // round half up at the alpha fraction position
   assign pm_rnd = pm_ff + signed'(ROUND_HALF);
   assign ps_rnd = ps_ff + signed'(ROUND_HALF);
   assign step_m = AW'(pm_rnd >>> F);
   assign step_s = AW'(ps_rnd >>> F);

   assign mag    = (mv2_ff < 0) ? -mv2_ff : mv2_ff;
   assign num    = DW'(mag);
   assign den    = DW'(sz2_ff);
   assign num100 = (DW+HUNDRED_BITS)'(num) * (DW+HUNDRED_BITS)'(SCALE_HUNDRED);

   assign trial    = {rem_ff, low_ff[QUOT_BITS-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});
   assign round_up = ({rem_ff, 1'b0} >= {1'b0, den_ff});
   assign q_round  = INDEX_WIDTH'(quot_ff) + INDEX_WIDTH'(round_up);
   assign q_clamp  = (q_round > INDEX_FULL) ? INDEX_FULL : q_round;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_value = rsp_value_ff;
   assign rsp_index_valid = rsp_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result may load in the cycle the old one is taken
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  if (kind == ITEM_SKIP) begin
                     res_value_ff <= '0;
                     res_valid_ff <= 1'b0;
                     state_ff     <= ST_OUT;
                  end else begin
                     x_ff  <= pop_x;
                     ax_ff <= pop_ax;
                     if (!seeded_ff) begin
                        mv1_ff    <= pop_x;
                        mv2_ff    <= pop_x;
                        sz1_ff    <= pop_ax;
                        sz2_ff    <= pop_ax;
                        seeded_ff <= 1'b1;
                        state_ff  <= ST_CHECK;
                     end else begin
                        state_ff <= ST_MUL1;
                     end
                  end
               end
            end
            ST_MUL1: begin
               pm_ff    <= d_mv1 * a1_s;
               ps_ff    <= d_sz1 * a1_s;
               state_ff <= ST_ADD1;
            end
            ST_ADD1: begin
               mv1_ff   <= mv1_ff + step_m;
               sz1_ff   <= sz1_ff + step_s;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               pm_ff    <= d_mv2 * a2_s;
               ps_ff    <= d_sz2 * a2_s;
               state_ff <= ST_ADD2;
            end
            ST_ADD2: begin
               mv2_ff   <= mv2_ff + step_m;
               sz2_ff   <= sz2_ff + step_s;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               neg_ff <= (mv2_ff < 0);
               if (sz2_ff <= 0) begin
                  res_value_ff <= '0;
                  res_valid_ff <= 1'b0;
                  state_ff     <= ST_OUT;
               end else if (num >= den) begin
                  // ratio at or beyond full scale saturates
                  res_value_ff <= (mv2_ff < 0) ? -signed'(INDEX_FULL) : signed'(INDEX_FULL);
                  res_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  // partial remainder holds the top of num*100*2^16, below den
                  rem_ff   <= num100[DW+HUNDRED_BITS-1:HUNDRED_BITS];
                  low_ff   <= {num100[HUNDRED_BITS-1:0], INDEX_FRAC'(0)};
                  den_ff   <= den;
                  quot_ff  <= '0;
                  cnt_ff   <= CNT_W'(QUOT_BITS - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= trial_ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
               quot_ff <= {quot_ff[QUOT_BITS-2:0], trial_ge};
               low_ff  <= {low_ff[QUOT_BITS-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  state_ff <= ST_ROUND;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_ROUND: begin
               res_value_ff <= neg_ff ? -signed'(q_clamp) : signed'(q_clamp);
               res_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_value_ff <= res_value_ff;
                  rsp_flag_ff  <= res_valid_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/true_strength_index_unit.sv =====
// True strength index unit: top level with the smoothing factor registers.
// Depends on tsi_pkg, tsi_front, tsi_queue and tsi_back.
//
// One price transaction in, one index transaction out, in order. The front
// end takes a price in the cycle it is offered while its two-entry queue has
// room; the back end works on one queued sample at a time. A sample with a
// momentum passes in the back end through the pop, four smoothing steps, a
// check, 23 iterations of the restoring divider, rounding and the output
// stage, so the divider limits the sustained rate; the back end takes no new
// sample before its output stage has handed the last one on. The sample that
// seeds the averages skips smoothing and the divider. Missing samples and the
// first price go straight to the output; a sample whose index saturates or
// whose denominator is not positive skips the divider.
// The result register holds one finished transaction while the back end
// starts on the next. Smoothing factors are Q1.ALPHA_FRAC_BITS; write them
// only while the unit is idle; values above one act as one.
module true_strength_index_unit
   import tsi_pkg::*;
#(
   parameter int PRICE_WIDTH     = PRICE_WIDTH_DEFAULT,
   parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PRICE_WIDTH-1:0]        req_price,
   input  logic                          req_price_missing,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [INDEX_WIDTH-1:0] rsp_index_value,
   output logic                          rsp_index_valid,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ALPHA_FRAC_BITS:0]      csr_data
);

   localparam int AL_W = ALPHA_FRAC_BITS + 1;
   localparam int QW   = PRICE_WIDTH + 2;
   localparam logic [63:0] FIRST_WIDE  =
      (64'(FIRST_ALPHA_RESET) << ALPHA_FRAC_BITS) >> ALPHA_RESET_FRAC;
   localparam logic [63:0] SECOND_WIDE =
      (64'(SECOND_ALPHA_RESET) << ALPHA_FRAC_BITS) >> ALPHA_RESET_FRAC;

   logic [AL_W-1:0] first_alpha_ff;
   logic [AL_W-1:0] second_alpha_ff;
   logic            q_push_valid;
   logic            q_push_ready;
   logic [QW-1:0]   q_push_data;
   logic            q_pop_valid;
   logic            q_pop_ready;
   logic [QW-1:0]   q_pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_alpha_ff  <= FIRST_WIDE[AL_W-1:0];
         second_alpha_ff <= SECOND_WIDE[AL_W-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_ALPHA:  first_alpha_ff  <= csr_data;
            CSR_SECOND_ALPHA: second_alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tsi_front #(
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_price         (req_price),
      .req_price_missing (req_price_missing),
      .push_valid        (q_push_valid),
      .push_ready        (q_push_ready),
      .push_data         (q_push_data)
   );

   tsi_queue #(
      .DATA_WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   tsi_back #(
      .PRICE_WIDTH     (PRICE_WIDTH),
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .first_alpha     (first_alpha_ff),
      .second_alpha    (second_alpha_ff),
      .pop_valid       (q_pop_valid),
      .pop_ready       (q_pop_ready),
      .pop_data        (q_pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_index_value (rsp_index_value),
      .rsp_index_valid (rsp_index_valid)
   );

endmodule
